// ===== src/pgr_pkg.sv =====
// ----------------------------------------------------------------------------
// pgr_pkg
// Types and fixed constants of the pedal generator regulator.
// ----------------------------------------------------------------------------
package pgr_pkg;

	typedef struct packed {
		logic signed [17:0] motor_speed;
		logic signed [15:0] motor_current;
		logic               kill_switch_on;
		logic               brake_front;
		logic               brake_rear;
		logic               stand_down;
	} pgr_in_t;

	typedef struct packed {
		logic [1:0]         drive_command;
		logic [24:0]        speed_target;
		logic               run_active;
		logic signed [15:0] timer_level;
	} pgr_out_t;

	// drive commands
	localparam logic [1:0] CMD_DISABLED     = 2'd0;
	localparam logic [1:0] CMD_ZERO_CURRENT = 2'd1;
	localparam logic [1:0] CMD_SPEED        = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PEDAL_TARGET = 2'd0;
	localparam logic [1:0] REG_BENCH_TEST   = 2'd1;
	localparam logic [1:0] REG_MOTOR_ENABLE = 2'd2;

	localparam logic [14:0] PEDAL_TARGET_RST = 15'd5120;

	// Q.8 constants (RAMP_IN_ERPM is in plain erpm)
	localparam logic [24:0]        SPEED_MIN_Q  = 25'd51200;
	localparam logic [24:0]        SPEED_MAX_Q  = 25'd1024000;
	localparam logic [24:0]        RELAX_STEP_Q = 25'd26;
	localparam logic signed [15:0] TIMER_MAX_Q  = 16'sd12800;
	localparam logic signed [15:0] TIMER_ARM_Q  = 16'sd6400;
	localparam logic signed [15:0] Q_ONE        = 16'sd256;
	localparam logic [17:0]        RAMP_IN_ERPM = 18'd1500;

	// constant division by reciprocal multiply, 32 fraction bits
	localparam logic [10:0] DIV_10     = 11'd10;
	localparam logic [10:0] DIV_1500   = 11'd1500;
	localparam logic [28:0] RECIP_10   = 29'd429496729;
	localparam logic [28:0] RECIP_1500 = 29'd2863311;

endpackage

// ===== src/pedal_generator_regulator_core.sv =====
// ----------------------------------------------------------------------------
// pedal_generator_regulator_core
// Per-tick speed filter, run/stop control and speed setpoint regulation.
// ----------------------------------------------------------------------------
// One transfer in per 1 ms tick gives exactly one transfer out. All divisions
// by constants run on one shared 28x29 multiplier (reciprocal, back-multiply,
// one-step correction), sequenced over up to three divisions per tick. An item
// holds the block from its transfer cycle: filter division and decision, a
// ramp multiply and division below 1500 erpm (current ramp in), one more
// division for a non-positive current error in run mode; a disabled motor
// skips all. in_ready is low meanwhile; a finished result sits in the output
// register until taken, and a later result waits in the block while it is.
module pedal_generator_regulator_core
	import pgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pgr_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pgr_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV_MUL, S_DIV_BACK, S_DIV_FIX, S_RAMP_MUL, S_DECIDE, S_DONE
	} state_t;

	typedef enum logic [1:0] {PH_FILT, PH_RAMP, PH_ERR} phase_t;

	function automatic logic [27:0] div_mag(input logic signed [28:0] n);
		logic signed [28:0] m;
		m = 29'sd9 - n;
		return n[28] ? m[27:0] : n[27:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7fff;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [24:0] sp_clamp(input logic signed [26:0] v);
		if (v < $signed({2'b00, SPEED_MIN_Q})) begin
			return SPEED_MIN_Q;
		end else if (v > $signed({2'b00, SPEED_MAX_Q})) begin
			return SPEED_MAX_Q;
		end
		return v[24:0];
	endfunction

	state_t state_q;
	logic   out_valid_q;
	pgr_out_t out_q;

	logic [14:0] pedal_target_q;
	logic        bench_test_q;
	logic        motor_enable_q;

	logic signed [25:0] smoothed_q;
	logic [24:0]        setpoint_q;
	logic               run_q;
	logic signed [15:0] timer_q;

	pgr_in_t     in_q;
	logic [27:0] div_a_q;
	logic        div_neg_q;
	logic        div_sel_q;
	phase_t      phase_q;
	logic [56:0] prod_q;
	logic [24:0] q0_q;
	logic [14:0] tgt_q;
	logic [1:0]  cmd_q;
	logic [24:0] tgt_out_q;

	logic        accept;
	logic        load_out;
	logic        cfg_wr;
	logic [27:0] mul_x;
	logic [28:0] mul_y;
	logic [56:0] mul_p;
	logic [10:0] div_d;
	logic [28:0] div_r;
	logic [24:0] quo;
	logic signed [25:0] div_q_s;

	logic signed [25:0] spd_q8;
	logic signed [26:0] diff;
	logic signed [28:0] num_filt;
	logic [17:0]        aspd;
	logic               ramp_on;

	logic               stop_cond;
	logic               run_now;
	logic signed [17:0] err;
	logic               err_pos;
	logic signed [21:0] err_x10;
	logic signed [28:0] num_err;
	logic [24:0]        sp_up;
	logic [24:0]        sp_err;

	logic signed [16:0] half_cur;
	logic signed [15:0] t_run;
	logic signed [15:0] t_inc;
	logic               arm;
	logic               run_after;
	logic signed [15:0] t_next;
	logic [24:0]        sp_base;
	logic [24:0]        sp_relax;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedal_target_q <= PEDAL_TARGET_RST;
			bench_test_q   <= 1'b0;
			motor_enable_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PEDAL_TARGET: pedal_target_q <= pwdata[14:0];
				REG_BENCH_TEST:   bench_test_q   <= pwdata[0];
				REG_MOTOR_ENABLE: motor_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PEDAL_TARGET: prdata = {17'b0, pedal_target_q};
			REG_BENCH_TEST:   prdata = {31'b0, bench_test_q};
			REG_MOTOR_ENABLE: prdata = {31'b0, motor_enable_q};
			default:          prdata = 32'b0;
		endcase
	end

	// shared multiplier
	assign div_d = div_sel_q ? DIV_1500 : DIV_10;

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			S_DIV_MUL: begin
				mul_x = div_a_q;
				mul_y = div_sel_q ? RECIP_1500 : RECIP_10;
			end
			S_DIV_BACK: begin
				mul_x = {3'b0, prod_q[56:32]};
				mul_y = {18'b0, div_d};
			end
			S_RAMP_MUL: begin
				mul_x = {13'b0, pedal_target_q};
				mul_y = {18'b0, aspd[10:0]};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_x * mul_y;

	// quotient correction
	assign div_r   = {1'b0, div_a_q} - prod_q[28:0];
	assign quo     = q0_q + 25'(div_r >= {18'b0, div_d});
	assign div_q_s = div_neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	// filter numerator at transfer in
	assign spd_q8   = $signed({in_data.motor_speed, 8'b0});
	assign diff     = 27'(spd_q8) - 27'(smoothed_q);
	assign num_filt = (29'(diff) <<< 1) + 29'sd5;

	assign aspd    = in_q.motor_speed[17] ? 18'(-in_q.motor_speed) : 18'(in_q.motor_speed);
	assign ramp_on = aspd < RAMP_IN_ERPM;

	// run / stop decision
	assign stop_cond = (!in_q.kill_switch_on || in_q.brake_front || in_q.brake_rear
		|| in_q.stand_down) && !bench_test_q;
	assign run_now = run_q && !stop_cond;
	assign err     = 18'sd0 - $signed({3'b000, tgt_q}) - 18'(in_q.motor_current);
	assign err_pos = err > 18'sd0;
	assign err_x10 = (22'(err) <<< 3) + (22'(err) <<< 1);
	assign num_err = 29'(err) + 29'sd5;
	assign sp_up   = sp_clamp($signed({2'b00, setpoint_q}) + 27'(err_x10));
	assign sp_err  = sp_clamp($signed({2'b00, setpoint_q}) + 27'(div_q_s));

	assign half_cur = (17'(in_q.motor_current) + 17'sd257) >>> 1;
	assign t_run    = sat16(18'(timer_q) - 18'(half_cur));
	assign t_inc    = sat16(18'(timer_q) + 18'(Q_ONE));
	assign arm      = (smoothed_q > $signed({1'b0, SPEED_MIN_Q})) && (t_inc >= TIMER_ARM_Q);

	always_comb begin
		if (run_now) begin
			if (in_q.motor_current < -Q_ONE) begin
				t_next    = (timer_q < TIMER_MAX_Q) ? timer_q + Q_ONE : timer_q;
				run_after = 1'b1;
			end else begin
				t_next    = t_run;
				run_after = (t_run > 16'sd0);
			end
		end else begin
			run_after = arm;
			if (smoothed_q > $signed({1'b0, SPEED_MIN_Q})) begin
				t_next = t_inc;
			end else if (timer_q > 16'sd0) begin
				t_next = timer_q - Q_ONE;
			end else begin
				t_next = timer_q;
			end
		end
	end

	assign sp_base = arm ? smoothed_q[24:0] : setpoint_q;

	always_comb begin
		if (sp_base > SPEED_MIN_Q) begin
			sp_relax = (sp_base - RELAX_STEP_Q < SPEED_MIN_Q) ? SPEED_MIN_Q
				: sp_base - RELAX_STEP_Q;
		end else if (sp_base < SPEED_MIN_Q) begin
			sp_relax = (sp_base + RELAX_STEP_Q > SPEED_MIN_Q) ? SPEED_MIN_Q
				: sp_base + RELAX_STEP_Q;
		end else begin
			sp_relax = sp_base;
		end
	end

	// sequencer, regulator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			smoothed_q  <= '0;
			setpoint_q  <= '0;
			run_q       <= 1'b0;
			timer_q     <= TIMER_MAX_Q;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= motor_enable_q ? S_DIV_MUL : S_DONE;
					end
				end
				S_DIV_MUL: begin
					state_q <= S_DIV_BACK;
				end
				S_DIV_BACK: begin
					state_q <= S_DIV_FIX;
				end
				S_DIV_FIX: begin
					case (phase_q)
						PH_FILT: begin
							smoothed_q <= smoothed_q + div_q_s;
							state_q    <= ramp_on ? S_RAMP_MUL : S_DECIDE;
						end
						PH_RAMP: state_q <= S_DECIDE;
						PH_ERR: begin
							setpoint_q <= sp_err;
							state_q    <= S_DONE;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RAMP_MUL: begin
					state_q <= S_DIV_MUL;
				end
				S_DECIDE: begin
					run_q   <= run_after;
					timer_q <= t_next;
					if (run_now) begin
						if (err_pos) begin
							setpoint_q <= sp_up;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_DIV_MUL;
						end
					end else begin
						setpoint_q <= sp_relax;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_q.drive_command <= cmd_q;
						out_q.speed_target  <= tgt_out_q;
						out_q.run_active    <= run_q;
						out_q.timer_level   <= timer_q;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					in_q <= in_data;
					if (motor_enable_q) begin
						div_a_q   <= div_mag(num_filt);
						div_neg_q <= num_filt[28];
						div_sel_q <= 1'b0;
						phase_q   <= PH_FILT;
					end else begin
						cmd_q     <= CMD_DISABLED;
						tgt_out_q <= '0;
					end
				end
			end
			S_DIV_MUL: begin
				prod_q <= mul_p;
			end
			S_DIV_BACK: begin
				q0_q   <= prod_q[56:32];
				prod_q <= mul_p;
			end
			S_DIV_FIX: begin
				if (phase_q == PH_RAMP) begin
					tgt_q <= quo[14:0];
				end else if (phase_q == PH_FILT && !ramp_on) begin
					tgt_q <= pedal_target_q;
				end
			end
			S_RAMP_MUL: begin
				div_a_q   <= mul_p[27:0];
				div_neg_q <= 1'b0;
				div_sel_q <= 1'b1;
				phase_q   <= PH_RAMP;
			end
			S_DECIDE: begin
				if (run_now) begin
					cmd_q     <= CMD_SPEED;
					tgt_out_q <= setpoint_q;
					if (!err_pos) begin
						div_a_q   <= div_mag(num_err);
						div_neg_q <= num_err[28];
						div_sel_q <= 1'b0;
						phase_q   <= PH_ERR;
					end
				end else begin
					cmd_q     <= CMD_ZERO_CURRENT;
					tgt_out_q <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/tb_pedal_generator_regulator_core.sv =====
// ----------------------------------------------------------------------------
// tb_pedal_generator_regulator_core
// Drives 1 ms ticks into the pedal generator regulator and checks each result
// against a tick-by-tick model of the speed filter, run/stop control, stop
// timer and setpoint regulation, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pedal_generator_regulator_core;
	import pgr_pkg::*;

	localparam longint SETPOINT_LOW   = 51200;
	localparam longint SETPOINT_HIGH  = 1024000;
	localparam longint SETPOINT_FIELD = 33554431;
	localparam longint TIMER_FULL     = 12800;
	localparam longint TIMER_ARM      = 6400;
	localparam longint ONE_AMP        = 256;
	localparam longint RAMP_ERPM      = 1500;
	localparam longint RELAX_STEP     = 26;
	localparam longint ERROR_GAIN     = 10;
	localparam int     SETTLE_CYCLES  = 16;
	localparam int     WATCHDOG_LIMIT = 1000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	pgr_in_t     in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pgr_out_t    out_data;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	pgr_in_t  pending_ticks[$];
	pgr_out_t expected_reports[$];

	logic [14:0] cfg_target = PEDAL_TARGET_RST;
	bit          cfg_bench  = 1'b0;
	bit          cfg_enable = 1'b1;

	longint smooth_q   = 0;
	longint setpoint_q = 0;
	longint timer_q    = TIMER_FULL;
	bit     running    = 1'b0;

	int mismatches   = 0;
	int send_gap     = 0;
	int recv_gap     = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;

	pedal_generator_regulator_core i_dut (.*);

	always #10 clk = ~clk;

	function automatic longint floor_div(input longint a, input longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp_q(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic predict_tick(input pgr_in_t t);
		longint   spd;
		longint   cur;
		longint   aspd;
		longint   tgt;
		longint   err;
		bit       stop_cond;
		pgr_out_t r;
		r = '0;
		r.drive_command = CMD_DISABLED;
		if (cfg_enable) begin
			spd = longint'(t.motor_speed);
			cur = longint'(t.motor_current);
			aspd = (spd < 0) ? -spd : spd;
			tgt = longint'(cfg_target);
			smooth_q = smooth_q + floor_div(2 * (spd * ONE_AMP - smooth_q) + 5, 10);
			if (aspd < RAMP_ERPM)
				tgt = (tgt * aspd) / RAMP_ERPM;
			stop_cond = !t.kill_switch_on || t.brake_front || t.brake_rear || t.stand_down;
			if (stop_cond && !cfg_bench)
				running = 1'b0;
			if (running) begin
				err = -tgt - cur;
				r.drive_command = CMD_SPEED;
				r.speed_target = 25'(clamp_q(setpoint_q, 0, SETPOINT_FIELD));
				if (err > 0)
					setpoint_q = setpoint_q + err * ERROR_GAIN;
				else
					setpoint_q = setpoint_q + floor_div(err + 5, 10);
				setpoint_q = clamp_q(setpoint_q, SETPOINT_LOW, SETPOINT_HIGH);
				if (cur < -ONE_AMP) begin
					if (timer_q < TIMER_FULL)
						timer_q = timer_q + ONE_AMP;
				end else begin
					timer_q = clamp_q(timer_q - (cur + ONE_AMP + 1) / 2, -32768, 32767);
					if (timer_q <= 0)
						running = 1'b0;
				end
				timer_q = clamp_q(timer_q, -32768, 32767);
			end else begin
				r.drive_command = CMD_ZERO_CURRENT;
				if (smooth_q > SETPOINT_LOW) begin
					timer_q = clamp_q(timer_q + ONE_AMP, -32768, 32767);
					if (timer_q >= TIMER_ARM) begin
						running = 1'b1;
						setpoint_q = smooth_q;
					end
				end else if (timer_q > 0) begin
					timer_q = timer_q - ONE_AMP;
				end
				if (setpoint_q > SETPOINT_LOW) begin
					setpoint_q = setpoint_q - RELAX_STEP;
					if (setpoint_q < SETPOINT_LOW)
						setpoint_q = SETPOINT_LOW;
				end else if (setpoint_q < SETPOINT_LOW) begin
					setpoint_q = setpoint_q + RELAX_STEP;
					if (setpoint_q > SETPOINT_LOW)
						setpoint_q = SETPOINT_LOW;
				end
				setpoint_q = clamp_q(setpoint_q, 0, SETPOINT_FIELD);
			end
		end
		r.run_active = running;
		r.timer_level = timer_q[15:0];
		expected_reports.push_back(r);
	endtask

	task automatic check_report(input pgr_out_t got);
		pgr_out_t want;
		if (expected_reports.size() == 0) begin
			$error("result transfer with no tick pending: %p", got);
			mismatches++;
		end else begin
			want = expected_reports.pop_front();
			if (got.drive_command !== want.drive_command) begin
				$error("drive_command: expected %0d, got %0d", want.drive_command,
					got.drive_command);
				mismatches++;
			end
			if (got.speed_target !== want.speed_target) begin
				$error("speed_target: expected %0d, got %0d", want.speed_target,
					got.speed_target);
				mismatches++;
			end
			if (got.run_active !== want.run_active) begin
				$error("run_active: expected %0d, got %0d", want.run_active, got.run_active);
				mismatches++;
			end
			if (got.timer_level !== want.timer_level) begin
				$error("timer_level: expected %0d, got %0d", want.timer_level,
					got.timer_level);
				mismatches++;
			end
		end
	endtask

	// tick source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_ticks.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_ticks.pop_front();
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result sink, model update and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			quiet_cycles <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_tick(in_data);
			if (out_valid && out_ready)
				check_report(out_data);
			if (recv_gap != 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					recv_gap <= $urandom_range(1, 4);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_PEDAL_TARGET: cfg_target = value[14:0];
			REG_BENCH_TEST:   cfg_bench = value[0];
			REG_MOTOR_ENABLE: cfg_enable = value[0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		while (pending_ticks.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_tick(input int speed, input int current, input bit kill,
		input bit front, input bit rear, input bit stand);
		pgr_in_t t;
		t.motor_speed = speed[17:0];
		t.motor_current = current[15:0];
		t.kill_switch_on = kill;
		t.brake_front = front;
		t.brake_rear = rear;
		t.stand_down = stand;
		pending_ticks.push_back(t);
	endtask

	task automatic push_noise();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		pending_ticks.push_back(raw[$bits(pgr_in_t)-1:0]);
	endtask

	task automatic push_directed();
		push_tick(0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(131071, -32768, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(131071, -32768, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(131071, 32767, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(-131072, -300, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(-131072, -32768, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(-131072, -257, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(-131072, -256, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(2000, -5120, 1'b1, 1'b1, 1'b0, 1'b0);
		push_tick(2000, -5120, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(2000, -5120, 1'b1, 1'b0, 1'b1, 1'b0);
		push_tick(1499, -4000, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(1499, -4000, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(1500, -5121, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(-1499, -5119, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(1, 0, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(1000, 32767, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(3000, -1000, 1'b1, 1'b0, 1'b0, 1'b1);
		push_tick(3000, -1000, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(0, 32767, 1'b0, 1'b1, 1'b1, 1'b1);
		push_tick(0, -32768, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(-1, -1, 1'b1, 1'b1, 1'b1, 1'b1);
	endtask

	// pedalling run, braked hold, coast-down or noise, picked at random
	task automatic push_mix(input int count);
		int left;
		int len;
		int kind;
		int base;
		int speed;
		int current;
		int stop_kind;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			base = $urandom_range(250, 3000);
			if ($urandom_range(0, 5) == 0)
				base = $urandom_range(1, 1499);
			if ($urandom_range(0, 7) == 0)
				base = -base;
			if (kind <= 5)
				len = $urandom_range(10, 40);
			else if (kind == 6)
				len = $urandom_range(20, 100);
			else if (kind == 7)
				len = $urandom_range(5, 30);
			else
				len = $urandom_range(1, 5);
			if (len > left)
				len = left;
			stop_kind = $urandom_range(0, 3);
			repeat (len) begin
				speed = base + $urandom_range(0, 100) - 50;
				if ($urandom_range(0, 9) == 0)
					current = $urandom_range(0, 3000);
				else
					current = -int'($urandom_range(0, 12000));
				if (kind <= 5)
					push_tick(speed, current, 1'b1, $urandom_range(0, 40) == 0,
						$urandom_range(0, 40) == 0, 1'b0);
				else if (kind == 6)
					push_tick(speed, current, stop_kind != 0, stop_kind == 1,
						stop_kind == 2, stop_kind == 3);
				else if (kind == 7)
					push_tick($urandom_range(0, 100) - 50, current,
						$urandom_range(0, 1) == 1, 1'b0, 1'b0, 1'b0);
				else
					push_noise();
			end
			left = left - len;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		push_directed();
		push_mix(300);
		settle();
		apb_write(REG_PEDAL_TARGET, 32'd0);
		apb_write(REG_BENCH_TEST, 32'd1);
		push_mix(200);
		settle();
		apb_write(REG_PEDAL_TARGET, 32'd32767);
		apb_write(REG_BENCH_TEST, 32'd0);
		push_mix(200);
		settle();
		apb_write(REG_MOTOR_ENABLE, 32'd0);
		push_mix(60);
		settle();
		apb_write(REG_MOTOR_ENABLE, 32'd1);
		apb_write(REG_PEDAL_TARGET, $urandom_range(1, 32766));
		apb_write(REG_BENCH_TEST, $urandom_range(0, 1));
		push_mix(250);
		settle();
		apb_write(REG_PEDAL_TARGET, 32'(PEDAL_TARGET_RST));
		apb_write(REG_BENCH_TEST, 32'd0);
		calm = 1'b1;
		push_mix(200);
		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
